[rtl/core/frsq_pkg.sv]
// shared constants, types and helper functions for the frame retransmit slot queue
package frsq_pkg;

    localparam int SLOT_COUNT  = 4;
    localparam int FRAME_BYTES = 10;
    localparam int FULL_BYTES  = 3;

    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LEN_W      = 4;
    localparam int LOW_W      = 64;
    localparam int HIGH_W     = 16;
    localparam int TMO_W      = 16;
    localparam int RETRY_W    = 8;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int SEND_SLOT_W = 2;

    localparam logic [OP_W-1:0] OP_TICK = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 3'd1;
    localparam logic [OP_W-1:0] OP_ACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_DONE = 3'd3;
    localparam logic [OP_W-1:0] OP_POLL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 8'd1;

    localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd100;
    localparam logic [RETRY_W-1:0] RETRY_RESET   = 8'd3;
    localparam logic [RETRY_W-1:0] RETRY_MAX     = '1;
    localparam logic [LEN_W-1:0]   LEN_MAX       = LEN_W'(FRAME_BYTES);

    typedef logic [SLOT_W-1:0] t_slot_idx;

    localparam t_slot_idx SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    typedef struct packed {
        logic              we;
        logic              clr;
        t_slot_idx         idx;
        logic [LOW_W-1:0]  low;
        logic [HIGH_W-1:0] high;
        logic [LEN_W-1:0]  len;
    } t_store_cmd;

    typedef struct packed {
        logic [LOW_W-1:0]  low;
        logic [HIGH_W-1:0] high;
        logic [LEN_W-1:0]  len;
        logic              full;
    } t_slot_rd;

    typedef struct packed {
        logic                   send_valid;
        logic [SEND_SLOT_W-1:0] send_slot;
        logic [LOW_W-1:0]       send_frame_low;
        logic [HIGH_W-1:0]      send_frame_high;
        logic [LEN_W-1:0]       send_length;
        logic                   load_accepted;
        logic                   dropped;
        logic                   transmitter_idle;
    } t_result;

    // byte enables for bytes 0 to 7
    function automatic logic [LOW_W-1:0] low_mask(input logic [LEN_W-1:0] len);
        logic [LOW_W-1:0] m;
        m = '0;
        for (int b = 0; b < LOW_W / 8; b++) begin
            m[b*8 +: 8] = {8{int'(len) > b}};
        end
        return m;
    endfunction

    // byte enables for bytes 8 and 9
    function automatic logic [HIGH_W-1:0] high_mask(input logic [LEN_W-1:0] len);
        logic [HIGH_W-1:0] m;
        m = '0;
        for (int b = 0; b < HIGH_W / 8; b++) begin
            m[b*8 +: 8] = {8{int'(len) > (b + LOW_W / 8)}};
        end
        return m;
    endfunction

    function automatic logic slot_full(input logic [LOW_W-1:0] low);
        return |low[FULL_BYTES*8-1:0];
    endfunction

    function automatic t_slot_idx next_slot(input t_slot_idx idx);
        return (idx == SLOT_LAST) ? '0 : idx + 1'b1;
    endfunction

endpackage

[rtl/core/frame_retransmit_slot_queue.sv]
// top level: config registers, event channel, slot store, sequencer and result register
//
// Event beats (op plus frame fields) arrive on i_valid / o_stall and are taken
// when i_valid is high and o_stall low. Each beat gives exactly one result beat
// on o_valid / i_stall, taken when o_valid is high and i_stall low.
// Tick, ack, transmit-done, unknown ops and polls that do not act go from idle
// through the done state into the output register. Loads and acting polls scan
// the slot ring one slot per cycle through the single store read port.
// One beat is in flight at a time; o_stall is high while the sequencer works
// and while a finished result still waits in the output register, so a stalled
// receiver holds the result unchanged and back-pressures the sender. With an
// open receiver the next beat is taken at the edge that takes the result.
// Limits are written on i_cfg_valid / o_cfg_ready (always ready) with index 0
// for the timeout limit and 1 for the retry limit; other indexes are ignored.
// Reset (synchronous, active low) empties all slots, clears the counters and
// ack flag, marks the transmitter idle and loads limits 100 and 3.
module frame_retransmit_slot_queue
    import frsq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [OP_W-1:0]        i_op,
    input  logic [LOW_W-1:0]       i_frame_low,
    input  logic [HIGH_W-1:0]      i_frame_high,
    input  logic [LEN_W-1:0]       i_frame_length,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_send_valid,
    output logic [SEND_SLOT_W-1:0] o_send_slot,
    output logic [LOW_W-1:0]       o_send_frame_low,
    output logic [HIGH_W-1:0]      o_send_frame_high,
    output logic [LEN_W-1:0]       o_send_length,
    output logic                   o_load_accepted,
    output logic                   o_dropped,
    output logic                   o_transmitter_idle,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [TMO_W-1:0]   r_timeout_limit;
    logic [RETRY_W-1:0] r_retry_limit;
    logic               r_out_valid;
    t_result            r_out;

    logic       w_start;
    logic       w_seq_idle;
    logic       w_seq_done;
    t_result    w_result;
    t_store_cmd w_cmd;
    t_slot_rd   w_rd;
    t_slot_idx  w_rd_idx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit <= TIMEOUT_RESET;
            r_retry_limit   <= RETRY_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TIMEOUT_LIMIT) begin
                r_timeout_limit <= i_cfg_data[TMO_W-1:0];
            end else if (i_cfg_index == CFG_RETRY_LIMIT) begin
                r_retry_limit <= i_cfg_data[RETRY_W-1:0];
            end
        end
    end

    // take a new beat only when the result slot is free or emptying this cycle
    assign o_stall = !(w_seq_idle && (!r_out_valid || !i_stall));
    assign w_start = i_valid && !o_stall;

    frsq_slot_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_rd_idx (w_rd_idx),
        .o_rd     (w_rd)
    );

    frsq_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_start),
        .i_op            (i_op),
        .i_frame_low     (i_frame_low),
        .i_frame_high    (i_frame_high),
        .i_frame_length  (i_frame_length),
        .i_timeout_limit (r_timeout_limit),
        .i_retry_limit   (r_retry_limit),
        .i_rd            (w_rd),
        .o_rd_idx        (w_rd_idx),
        .o_cmd           (w_cmd),
        .o_idle          (w_seq_idle),
        .o_done          (w_seq_done),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_seq_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_seq_done) begin
            r_out <= w_result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_send_valid       = r_out.send_valid;
    assign o_send_slot        = r_out.send_slot;
    assign o_send_frame_low   = r_out.send_frame_low;
    assign o_send_frame_high  = r_out.send_frame_high;
    assign o_send_length      = r_out.send_length;
    assign o_load_accepted    = r_out.load_accepted;
    assign o_dropped          = r_out.dropped;
    assign o_transmitter_idle = r_out.transmitter_idle;

endmodule

[rtl/core/frsq_slot_store.sv]
// slot storage: frame bytes and length per slot, masked write, clear and one read port
module frsq_slot_store
    import frsq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_cmd i_cmd,
    input  t_slot_idx  i_rd_idx,
    output t_slot_rd   o_rd
);

    logic [LOW_W-1:0]  r_low  [SLOT_COUNT];
    logic [HIGH_W-1:0] r_high [SLOT_COUNT];
    logic [LEN_W-1:0]  r_len  [SLOT_COUNT];

    logic [LOW_W-1:0]  w_lm;
    logic [HIGH_W-1:0] w_hm;

    assign w_lm = low_mask(i_cmd.len);
    assign w_hm = high_mask(i_cmd.len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                r_low[s]  <= '0;
                r_high[s] <= '0;
                r_len[s]  <= '0;
            end
        end else if (i_cmd.we) begin
            // partial load keeps the bytes beyond the length
            r_low[i_cmd.idx]  <= (r_low[i_cmd.idx] & ~w_lm) | (i_cmd.low & w_lm);
            r_high[i_cmd.idx] <= (r_high[i_cmd.idx] & ~w_hm) | (i_cmd.high & w_hm);
            r_len[i_cmd.idx]  <= i_cmd.len;
        end else if (i_cmd.clr) begin
            r_low[i_cmd.idx]  <= '0;
            r_high[i_cmd.idx] <= '0;
        end
    end

    assign o_rd.low  = r_low[i_rd_idx];
    assign o_rd.high = r_high[i_rd_idx];
    assign o_rd.len  = r_len[i_rd_idx];
    assign o_rd.full = slot_full(r_low[i_rd_idx]);

endmodule

[rtl/core/frsq_seq.sv]
// sequencer: link state, one-slot-per-cycle scan for loads and polls, result assembly
module frsq_seq
    import frsq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [OP_W-1:0]         i_op,
    input  logic [LOW_W-1:0]        i_frame_low,
    input  logic [HIGH_W-1:0]       i_frame_high,
    input  logic [LEN_W-1:0]        i_frame_length,
    input  logic [TMO_W-1:0]        i_timeout_limit,
    input  logic [RETRY_W-1:0]      i_retry_limit,
    input  t_slot_rd                i_rd,
    output t_slot_idx               o_rd_idx,
    output t_store_cmd              o_cmd,
    output logic                    o_idle,
    output logic                    o_done,
    output t_result                 o_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic               r_is_load, n_is_load;
    t_slot_idx          r_idx, n_idx;
    t_slot_idx          r_cnt, n_cnt;
    t_slot_idx          r_cur, n_cur;
    logic [RETRY_W-1:0] r_retry, n_retry;
    logic [TMO_W-1:0]   r_tmo, n_tmo;
    logic               r_ack, n_ack;
    logic               r_txidle, n_txidle;
    logic [LOW_W-1:0]   r_flo, n_flo;
    logic [HIGH_W-1:0]  r_fhi, n_fhi;
    logic [LEN_W-1:0]   r_flen, n_flen;
    t_result            r_res, n_res;

    logic [RETRY_W-1:0] w_retry_sat;
    logic               w_first;
    logic               w_drop;
    logic               w_last;
    logic [31:0]        w_idx_ext;

    assign w_first     = (r_cnt == '0);
    assign w_last      = (r_cnt == SLOT_LAST);
    assign w_retry_sat = (r_retry == RETRY_MAX) ? r_retry : r_retry + 1'b1;
    assign w_drop      = w_first && (w_retry_sat > i_retry_limit);
    assign w_idx_ext   = 32'(r_idx);

    assign o_rd_idx = r_idx;
    assign o_idle   = (r_state == ST_IDLE);
    assign o_done   = (r_state == ST_DONE);

    always_comb begin
        o_result                  = r_res;
        o_result.transmitter_idle = r_txidle;
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_cmd.low  = r_flo;
        o_cmd.high = r_fhi;
        o_cmd.len  = r_flen;
        if (r_state == ST_SCAN) begin
            if (r_is_load) begin
                o_cmd.we = !i_rd.full;
            end else begin
                o_cmd.clr = i_rd.full && w_drop;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_is_load = r_is_load;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_cur     = r_cur;
        n_retry   = r_retry;
        n_tmo     = r_tmo;
        n_ack     = r_ack;
        n_txidle  = r_txidle;
        n_flo     = r_flo;
        n_fhi     = r_fhi;
        n_flen    = r_flen;
        n_res     = r_res;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_res     = '0;
                    n_state   = ST_DONE;
                    n_idx     = r_cur;
                    n_cnt     = '0;
                    n_is_load = (i_op == OP_LOAD);
                    n_flo     = i_frame_low;
                    n_fhi     = i_frame_high;
                    n_flen    = (i_frame_length > LEN_MAX) ? LEN_MAX : i_frame_length;
                    unique case (i_op)
                        OP_TICK: begin
                            if (r_tmo < i_timeout_limit) begin
                                n_tmo = r_tmo + 1'b1;
                            end
                        end
                        OP_LOAD: begin
                            n_state = ST_SCAN;
                        end
                        OP_ACK: begin
                            n_ack = 1'b1;
                        end
                        OP_DONE: begin
                            n_txidle = 1'b1;
                        end
                        OP_POLL: begin
                            if (r_txidle && (r_tmo >= i_timeout_limit || r_ack)) begin
                                n_ack   = 1'b0;
                                n_tmo   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_idx = next_slot(r_idx);
                n_cnt = r_cnt + 1'b1;
                if (w_last) begin
                    n_state = ST_DONE;
                end
                if (r_is_load) begin
                    if (!i_rd.full) begin
                        n_res.load_accepted = 1'b1;
                        n_state = ST_DONE;
                    end
                end else if (i_rd.full) begin
                    if (w_first) begin
                        n_retry = w_retry_sat;
                    end
                    if (w_drop) begin
                        // current slot out of retries: clear it and keep scanning
                        n_retry       = '0;
                        n_res.dropped = 1'b1;
                    end else begin
                        n_res.send_valid      = 1'b1;
                        n_res.send_slot       = w_idx_ext[SEND_SLOT_W-1:0];
                        n_res.send_frame_low  = i_rd.low & low_mask(i_rd.len);
                        n_res.send_frame_high = i_rd.high & high_mask(i_rd.len);
                        n_res.send_length     = i_rd.len;
                        n_cur    = r_idx;
                        n_txidle = 1'b0;
                        n_state  = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_is_load <= 1'b0;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_cur     <= '0;
            r_retry   <= '0;
            r_tmo     <= '0;
            r_ack     <= 1'b0;
            r_txidle  <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_is_load <= n_is_load;
            r_idx     <= n_idx;
            r_cnt     <= n_cnt;
            r_cur     <= n_cur;
            r_retry   <= n_retry;
            r_tmo     <= n_tmo;
            r_ack     <= n_ack;
            r_txidle  <= n_txidle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flo  <= n_flo;
        r_fhi  <= n_fhi;
        r_flen <= n_flen;
        r_res  <= n_res;
    end

endmodule
